// ===== rtl/tgc_pkg.sv =====
// Shared types and constants for the touch gesture classifier.
// No dependencies; imported by every rtl module of the block.
`default_nettype none

package tgc_pkg;

	// coordinate datapath width
	localparam int unsigned COORD_BITS = 12;

	// x scale 800/1024 = 25/32
	localparam int unsigned SX_MUL   = 25;
	localparam int unsigned SX_SHIFT = 5;

	// y scale 480/600 = 4/5, divide by 5 through a rounded-up reciprocal
	localparam int unsigned SY_SHIFT = COORD_BITS + 5;
	localparam int unsigned SY_MUL   = (2 ** SY_SHIFT + 4) / 5;

	// register reset values
	localparam logic [15:0] LONG_PRESS_RST   = 16'd500;
	localparam logic [15:0] DOUBLE_CLICK_RST = 16'd800;

	// point valid flag positions
	localparam int unsigned FLAG_FX = 0;
	localparam int unsigned FLAG_FY = 1;
	localparam int unsigned FLAG_LX = 2;
	localparam int unsigned FLAG_LY = 3;
	localparam logic [3:0] FLAGS_ALL   = 4'b1111;
	localparam logic [3:0] FLAGS_FIRST = 4'b0011;

	typedef logic [COORD_BITS-1:0] coord_t;

	typedef enum logic [1:0] {
		OP_X_SAMPLE = 2'd0,
		OP_Y_SAMPLE = 2'd1,
		OP_RELEASE  = 2'd2,
		OP_TICK     = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		G_NONE   = 3'd0,
		G_UP     = 3'd1,
		G_DOWN   = 3'd2,
		G_LEFT   = 3'd3,
		G_RIGHT  = 3'd4,
		G_CLICK  = 3'd5,
		G_DOUBLE = 3'd6,
		G_LONG   = 3'd7
	} gesture_t;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_TOUCH   = 2'd1,
		PH_PENDING = 2'd2,
		PH_SECOND  = 2'd3
	} phase_t;

	typedef enum logic {
		REG_LONG_PRESS   = 1'b0,
		REG_DOUBLE_CLICK = 1'b1
	} cfg_reg_t;

	// first and latest point of the current touch
	typedef struct packed {
		coord_t first_x;
		coord_t first_y;
		coord_t latest_x;
		coord_t latest_y;
	} point_set_t;

endpackage

`default_nettype wire

// ===== rtl/touch_gesture_classifier.sv =====
// Touch gesture classifier top level: input register, classification, result register.
// Depends on tgc_pkg, tgc_scale and tgc_swipe.
//
//  channel  | handshake               | beat payload
//  ---------+-------------------------+-----------------------------------------
//  in       | in_valid / in_stall     | opcode, coord_value, time_ms
//  out      | out_valid / out_stall   | gesture, point_x, point_y, hold_ms
//  config   | cfg_en (no wait)        | cfg_index, cfg_data
//
// One event per cycle while in_stall is low; a result enters the result register when
// its event leaves the event register, and the sink takes it from that register.
// The event register feeds the classifier, whose output is loaded into the result register.
// arst_n clears phase, flags, points, times and both valid bits; registers
// return to 500 ms and 800 ms. in_stall rises only when the event register
// holds a beat and the result register is full and stalled.
`default_nettype none

module touch_gesture_classifier (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_en,
	input  wire         cfg_index,
	input  wire  [15:0] cfg_data,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [1:0]  opcode,
	input  wire  [11:0] coord_value,
	input  wire  [31:0] time_ms,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [2:0]  gesture,
	output logic [11:0] point_x,
	output logic [11:0] point_y,
	output logic [31:0] hold_ms
);
	import tgc_pkg::*;

	// configuration
	logic [15:0] long_press_q;
	logic [15:0] double_click_q;

	// event register
	logic        valid_s1;
	opcode_t     op_s1;
	coord_t      coord_s1;
	logic [31:0] time_s1;
	logic        adv_s1;

	// touch state
	phase_t      phase_q,  phase_d;
	point_set_t  pts_q,    pts_d;
	logic [3:0]  flags_q,  flags_d;
	logic [31:0] start_q,  start_d;
	logic [31:0] tap_end_q, tap_end_d;
	coord_t      tap_x_q,  tap_x_d;
	coord_t      tap_y_q,  tap_y_d;

	// result
	logic        emit;
	gesture_t    res_g;
	coord_t      res_x;
	coord_t      res_y;
	logic [31:0] res_hold;
	logic        out_valid_q;
	gesture_t    gesture_q;
	coord_t      point_x_q;
	coord_t      point_y_q;
	logic [31:0] hold_q;

	// datapath helpers
	coord_t      sx;
	coord_t      sy;
	gesture_t    swipe_dir;
	logic        coord_zero;
	logic [31:0] elapsed;
	logic        in_window;
	logic [31:0] hold;
	logic [31:0] tap_hold;

	// write registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_q   <= LONG_PRESS_RST;
			double_click_q <= DOUBLE_CLICK_RST;
		end else if (cfg_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_LONG_PRESS:   long_press_q   <= cfg_data;
				REG_DOUBLE_CLICK: double_click_q <= cfg_data;
				default:          ;
			endcase
		end
	end

	// advance the event register when the result register can take a beat
	assign adv_s1   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1    <= opcode_t'(opcode);
			coord_s1 <= COORD_BITS'(coord_value);
			time_s1  <= time_ms;
		end
	end

	tgc_scale u_scale (
		.raw      (coord_s1),
		.scaled_x (sx),
		.scaled_y (sy)
	);

	tgc_swipe u_swipe (
		.pts (pts_q),
		.dir (swipe_dir)
	);

	assign coord_zero = coord_s1 == '0;
	assign elapsed    = time_s1 - tap_end_q;
	assign in_window  = elapsed < {16'd0, double_click_q};
	assign hold       = flags_q[FLAG_FX] ? time_s1 - start_q : 32'd0;
	assign tap_hold   = tap_end_q - start_q;

	// classify the event and work out the next touch state
	always_comb begin
		phase_d   = phase_q;
		pts_d     = pts_q;
		flags_d   = flags_q;
		start_d   = start_q;
		tap_end_d = tap_end_q;
		tap_x_d   = tap_x_q;
		tap_y_d   = tap_y_q;
		emit      = 1'b0;
		res_g     = G_NONE;
		res_x     = pts_q.first_x;
		res_y     = pts_q.first_y;
		res_hold  = hold;
		case (op_s1)
			OP_X_SAMPLE: begin
				if (!coord_zero) begin
					if (phase_q == PH_PENDING) begin
						if (in_window) begin
							phase_d = PH_SECOND;
						end else begin
							emit     = 1'b1;
							res_g    = G_CLICK;
							res_x    = tap_x_q;
							res_y    = tap_y_q;
							res_hold = tap_hold;
							phase_d  = PH_TOUCH;
						end
					end else if (phase_q == PH_IDLE) begin
						phase_d = PH_TOUCH;
					end
					if (!flags_q[FLAG_FX]) begin
						pts_d.first_x    = sx;
						start_d          = time_s1;
						flags_d[FLAG_FX] = 1'b1;
					end else begin
						pts_d.latest_x   = sx;
						flags_d[FLAG_LX] = 1'b1;
					end
				end
			end
			OP_Y_SAMPLE: begin
				if (!coord_zero) begin
					if (phase_q == PH_IDLE) begin
						phase_d = PH_TOUCH;
					end
					if (!flags_q[FLAG_FY]) begin
						pts_d.first_y    = sy;
						flags_d[FLAG_FY] = 1'b1;
					end else begin
						pts_d.latest_y   = sy;
						flags_d[FLAG_LY] = 1'b1;
					end
				end
			end
			OP_RELEASE: begin
				// every release drops the touch points
				pts_d   = '0;
				flags_d = '0;
				if (phase_q == PH_PENDING) begin
					phase_d = PH_PENDING;
				end else if (phase_q == PH_SECOND) begin
					emit    = 1'b1;
					res_g   = G_DOUBLE;
					res_x   = tap_x_q;
					res_y   = tap_y_q;
					phase_d = PH_IDLE;
				end else if (flags_q == FLAGS_ALL) begin
					emit    = 1'b1;
					res_g   = swipe_dir;
					phase_d = PH_IDLE;
				end else if (flags_q == FLAGS_FIRST) begin
					if (hold > {16'd0, long_press_q}) begin
						emit    = 1'b1;
						res_g   = G_LONG;
						phase_d = PH_IDLE;
					end else begin
						// hold the tap until the window decides
						tap_x_d   = pts_q.first_x;
						tap_y_d   = pts_q.first_y;
						tap_end_d = time_s1;
						phase_d   = PH_PENDING;
					end
				end else begin
					emit    = 1'b1;
					res_g   = G_NONE;
					phase_d = PH_IDLE;
				end
			end
			OP_TICK: begin
				if (phase_q == PH_PENDING && !in_window) begin
					emit     = 1'b1;
					res_g    = G_CLICK;
					res_x    = tap_x_q;
					res_y    = tap_y_q;
					res_hold = tap_hold;
					phase_d  = (flags_q != '0) ? PH_TOUCH : PH_IDLE;
				end
			end
			default: ;
		endcase
	end

	// commit state when the event leaves the event register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			pts_q     <= '0;
			flags_q   <= '0;
			start_q   <= '0;
			tap_end_q <= '0;
			tap_x_q   <= '0;
			tap_y_q   <= '0;
		end else if (adv_s1) begin
			phase_q   <= phase_d;
			pts_q     <= pts_d;
			flags_q   <= flags_d;
			start_q   <= start_d;
			tap_end_q <= tap_end_d;
			tap_x_q   <= tap_x_d;
			tap_y_q   <= tap_y_d;
		end
	end

	// result register: drain on a taken beat, load on a new result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit) begin
			gesture_q <= res_g;
			point_x_q <= res_x;
			point_y_q <= res_y;
			hold_q    <= res_hold;
		end
	end

	assign out_valid = out_valid_q;
	assign gesture   = gesture_q;
	assign point_x   = 12'(point_x_q);
	assign point_y   = 12'(point_y_q);
	assign hold_ms   = hold_q;

	// an idle block holds no touch points
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> flags_q == '0)
		else $error("idle phase with touch points held");

	// a pending tap never carries an x sample
	a_pending_no_x: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PENDING |-> !flags_q[FLAG_FX] && !flags_q[FLAG_LX])
		else $error("x sample held while tap pending");

	// a latest point needs a first point
	a_latest_after_first: assert property (@(posedge clk) disable iff (!arst_n)
		(!flags_q[FLAG_LX] || flags_q[FLAG_FX]) && (!flags_q[FLAG_LY] || flags_q[FLAG_FY]))
		else $error("latest point without first point");

	// a new result comes only from an event that left the event register
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv_s1))
		else $error("result without an event");

endmodule

`default_nettype wire

// ===== rtl/tgc_scale.sv =====
// Scales a raw panel coordinate to the 800 by 480 screen grid.
// Depends on tgc_pkg for the coordinate width and scale constants.
`default_nettype none

module tgc_scale (
	input  wire  tgc_pkg::coord_t raw,
	output tgc_pkg::coord_t       scaled_x,
	output tgc_pkg::coord_t       scaled_y
);
	import tgc_pkg::*;

	localparam int unsigned PX_W = COORD_BITS + SX_SHIFT;
	localparam int unsigned PY_W = COORD_BITS + SY_SHIFT;

	logic [PX_W-1:0]       prod_x;
	logic [COORD_BITS+1:0] raw_x4;
	logic [PY_W-1:0]       prod_y;

	// x: multiply by 25, drop five bits
	assign prod_x   = PX_W'(raw) * PX_W'(SX_MUL);
	assign scaled_x = prod_x[SX_SHIFT +: COORD_BITS];

	// y: times four, then divide by five through the reciprocal
	assign raw_x4   = {raw, 2'b00};
	assign prod_y   = PY_W'(raw_x4) * PY_W'(SY_MUL);
	assign scaled_y = prod_y[SY_SHIFT +: COORD_BITS];

endmodule

`default_nettype wire

// ===== rtl/tgc_swipe.sv =====
// Picks the swipe direction from the first and latest touch points.
// Depends on tgc_pkg for point_set_t and gesture_t.
`default_nettype none

module tgc_swipe (
	input  wire  tgc_pkg::point_set_t pts,
	output tgc_pkg::gesture_t         dir
);
	import tgc_pkg::*;

	coord_t adx;
	coord_t ady;
	logic   y_up_or_eq;
	logic   x_right;

	// absolute deltas
	assign y_up_or_eq = pts.latest_y >= pts.first_y;
	assign x_right    = pts.latest_x > pts.first_x;
	assign adx = (pts.latest_x >= pts.first_x) ? pts.latest_x - pts.first_x
	                                           : pts.first_x - pts.latest_x;
	assign ady = y_up_or_eq ? pts.latest_y - pts.first_y : pts.first_y - pts.latest_y;

	// vertical wins ties
	always_comb begin
		if (adx <= ady) begin
			dir = y_up_or_eq ? G_DOWN : G_UP;
		end else begin
			dir = x_right ? G_RIGHT : G_LEFT;
		end
	end

endmodule

`default_nettype wire

// ===== tb/touch_gesture_classifier_test.sv =====
// Self-checking bench for touch_gesture_classifier: drives event beats and
// compares every result beat against a built-in gesture tracker.
// Depends on tgc_pkg and the touch_gesture_classifier RTL.
`default_nettype none

module touch_gesture_classifier_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tgc_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 3000;
	localparam int unsigned CHOKE_CYCLES   = 150;
	localparam int unsigned PHASE_ITEMS    = 105;

	typedef struct packed {
		gesture_t    gesture;
		coord_t      px;
		coord_t      py;
		logic [31:0] hold;
	} gesture_beat_t;

	// Tracks one touch at a time and queues the gesture beats it must produce.
	class gesture_tracker;
		logic [15:0]   press_limit;
		logic [15:0]   window_ms;
		phase_t        stage;
		coord_t        start_x, start_y, last_x, last_y;
		logic [3:0]    seen;
		logic [31:0]   touch_t0, tap_release_ms;
		coord_t        tap_px, tap_py;
		gesture_beat_t gestures_due[$];
		int            failures;

		function new();
			press_limit    = LONG_PRESS_RST;
			window_ms      = DOUBLE_CLICK_RST;
			stage          = PH_IDLE;
			touch_t0       = '0;
			tap_release_ms = '0;
			tap_px         = '0;
			tap_py         = '0;
			failures       = 0;
			drop_touch();
		endfunction

		function void drop_touch();
			seen    = '0;
			start_x = '0;
			start_y = '0;
			last_x  = '0;
			last_y  = '0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [15:0] val);
			if (idx == REG_LONG_PRESS)
				press_limit = val;
			else
				window_ms = val;
		endfunction

		function void add_result(gesture_t g, coord_t px, coord_t py, logic [31:0] hold);
			gesture_beat_t beat;
			beat.gesture = g;
			beat.px      = px;
			beat.py      = py;
			beat.hold    = hold;
			gestures_due.push_back(beat);
		endfunction

		function int outstanding();
			return gestures_due.size();
		endfunction

		function void note_event(opcode_t op, coord_t v, logic [31:0] t);
			int unsigned wide;
			coord_t      scaled, adx, ady;
			logic [31:0] since, hold, tap_hold;
			gesture_t    g;
			wide     = v;
			since    = t - tap_release_ms;
			tap_hold = tap_release_ms - touch_t0;
			hold     = seen[FLAG_FX] ? t - touch_t0 : 32'd0;
			case (op)
			OP_X_SAMPLE: begin
				if (v == '0)
					return;
				scaled = coord_t'(wide * 800 / 1024);
				if (stage == PH_PENDING) begin
					if (since < window_ms) begin
						stage = PH_SECOND;
					end else begin
						add_result(G_CLICK, tap_px, tap_py, tap_hold);
						stage = PH_TOUCH;
					end
				end else if (stage == PH_IDLE) begin
					stage = PH_TOUCH;
				end
				if (!seen[FLAG_FX]) begin
					start_x       = scaled;
					touch_t0      = t;
					seen[FLAG_FX] = 1'b1;
				end else begin
					last_x        = scaled;
					seen[FLAG_LX] = 1'b1;
				end
			end
			OP_Y_SAMPLE: begin
				if (v == '0)
					return;
				scaled = coord_t'(wide * 480 / 600);
				if (stage == PH_IDLE)
					stage = PH_TOUCH;
				if (!seen[FLAG_FY]) begin
					start_y       = scaled;
					seen[FLAG_FY] = 1'b1;
				end else begin
					last_y        = scaled;
					seen[FLAG_LY] = 1'b1;
				end
			end
			OP_RELEASE: begin
				if (stage == PH_PENDING) begin
					// stray contact while a tap waits: forget it, keep the tap
					drop_touch();
				end else if (stage == PH_SECOND) begin
					add_result(G_DOUBLE, tap_px, tap_py, hold);
					drop_touch();
					stage = PH_IDLE;
				end else if (seen == FLAGS_ALL) begin
					adx = (last_x >= start_x) ? last_x - start_x : start_x - last_x;
					ady = (last_y >= start_y) ? last_y - start_y : start_y - last_y;
					if (adx <= ady) begin
						if (last_y >= start_y)
							g = G_DOWN;
						else
							g = G_UP;
					end else begin
						if (last_x > start_x)
							g = G_RIGHT;
						else
							g = G_LEFT;
					end
					add_result(g, start_x, start_y, hold);
					drop_touch();
					stage = PH_IDLE;
				end else if (seen == FLAGS_FIRST && hold <= press_limit) begin
					// short single point: hold the tap until the window decides
					tap_px         = start_x;
					tap_py         = start_y;
					tap_release_ms = t;
					drop_touch();
					stage = PH_PENDING;
				end else begin
					g = G_NONE;
					if (seen == FLAGS_FIRST)
						g = G_LONG;
					add_result(g, start_x, start_y, hold);
					drop_touch();
					stage = PH_IDLE;
				end
			end
			default: begin
				if (stage == PH_PENDING && since >= window_ms) begin
					add_result(G_CLICK, tap_px, tap_py, tap_hold);
					if (seen != '0)
						stage = PH_TOUCH;
					else
						stage = PH_IDLE;
				end
			end
			endcase
		endfunction

		function void check_result(logic [2:0] g, coord_t px, coord_t py, logic [31:0] hold);
			gesture_beat_t want;
			if (gestures_due.size() == 0) begin
				$error("unexpected result beat: gesture %0d x %0d y %0d hold %0d",
					g, px, py, hold);
				failures++;
				return;
			end
			want = gestures_due.pop_front();
			if (g !== want.gesture) begin
				$error("gesture: expected %0d, got %0d", want.gesture, g);
				failures++;
			end
			if (px !== want.px) begin
				$error("point_x: expected %0d, got %0d", want.px, px);
				failures++;
			end
			if (py !== want.py) begin
				$error("point_y: expected %0d, got %0d", want.py, py);
				failures++;
			end
			if (hold !== want.hold) begin
				$error("hold_ms: expected %0d, got %0d", want.hold, hold);
				failures++;
			end
		endfunction
	endclass

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        cfg_en       = 1'b0;
	cfg_reg_t    cfg_index    = REG_LONG_PRESS;
	logic [15:0] cfg_data     = '0;
	logic        in_valid     = 1'b0;
	logic        in_stall;
	opcode_t     op_drv       = OP_X_SAMPLE;
	coord_t      coord_value  = '0;
	logic [31:0] time_ms      = '0;
	logic        out_valid;
	logic        out_stall    = 1'b0;
	logic [2:0]  gesture;
	coord_t      point_x, point_y;
	logic [31:0] hold_ms;

	gesture_tracker tracker = new();

	logic [31:0] stamp_ms;
	int unsigned items_sent   = 0;
	bit          idle_on      = 1'b1;
	int unsigned chokes_asked = 0;
	int unsigned chokes_done  = 0;
	int unsigned quiet_cycles = 0;

	touch_gesture_classifier uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_en      (cfg_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (op_drv),
		.coord_value (coord_value),
		.time_ms     (time_ms),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.gesture     (gesture),
		.point_x     (point_x),
		.point_y     (point_y),
		.hold_ms     (hold_ms)
	);

	always #5 clk = ~clk;

	// check every result beat taken by the sink
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_result(gesture, point_x, point_y, hold_ms);
	end

	// end the run when neither channel moves a beat for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// result sink: random stall before each beat while idle_on is set, long hold-off on request
	initial begin : result_sink
		int unsigned pause;
		wait (arst_n);
		@(negedge clk);
		forever begin
			pause = idle_on ? $urandom_range(0, 3) : 0;
			if (chokes_done != chokes_asked) begin
				pause = CHOKE_CYCLES;
				chokes_done++;
			end
			if (pause != 0) begin
				out_stall <= 1'b1;
				repeat (pause) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	function automatic coord_t pick_coord();
		case ($urandom_range(0, 15))
		0: return 12'hFFF;
		1: return 12'd1;
		default: return coord_t'($urandom_range(1, 4095));
		endcase
	endfunction

	function automatic coord_t noise_coord();
		if ($urandom_range(0, 5) == 0)
			return '0;
		return pick_coord();
	endfunction

	// time step that lands on, around or far from a threshold
	function automatic int unsigned pick_span(int unsigned limit);
		if ($urandom_range(0, 19) == 0)
			return $urandom();
		case ($urandom_range(0, 5))
		0: return 0;
		1: return limit - 1;
		2: return limit;
		3: return limit + 1;
		4: return $urandom_range(0, 2 * limit + 2);
		default: return $urandom_range(0, 40);
		endcase
	endfunction

	// offer one event beat and hold it until taken; returns at a falling edge
	task automatic send_event(opcode_t op, coord_t v, int unsigned dt);
		int unsigned gap;
		gap = idle_on ? $urandom_range(0, 3) : 0;
		stamp_ms = stamp_ms + dt;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		op_drv      <= op;
		coord_value <= v;
		time_ms     <= stamp_ms;
		do @(posedge clk); while (in_stall);
		tracker.note_event(op, v, stamp_ms);
		if (op == OP_RELEASE || op == OP_TICK || v != '0)
			items_sent++;
		@(negedge clk);
	endtask

	// one contact point of a touch, x or y first
	task automatic send_point(int unsigned dt);
		if ($urandom_range(0, 1)) begin
			send_event(OP_X_SAMPLE, pick_coord(), dt);
			send_event(OP_Y_SAMPLE, pick_coord(), $urandom_range(0, 5));
		end else begin
			send_event(OP_Y_SAMPLE, pick_coord(), dt);
			send_event(OP_X_SAMPLE, pick_coord(), $urandom_range(0, 5));
		end
	endtask

	// drop valid and wait out every pending result plus the pipeline
	task automatic settle();
		in_valid <= 1'b0;
		while (tracker.outstanding() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic program_regs(logic [15:0] press, logic [15:0] window);
		cfg_en    <= 1'b1;
		cfg_index <= REG_LONG_PRESS;
		cfg_data  <= press;
		@(posedge clk);
		tracker.set_reg(REG_LONG_PRESS, press);
		@(negedge clk);
		cfg_index <= REG_DOUBLE_CLICK;
		cfg_data  <= window;
		@(posedge clk);
		tracker.set_reg(REG_DOUBLE_CLICK, window);
		@(negedge clk);
		cfg_en <= 1'b0;
	endtask

	task automatic directed_events();
		// release with no contact, then an ignored zero sample
		send_event(OP_RELEASE, 12'd0, 5);
		send_event(OP_X_SAMPLE, 12'd0, 1);
		// corner-to-origin swipe across the timestamp wrap
		send_event(OP_X_SAMPLE, 12'hFFF, 3);
		send_event(OP_Y_SAMPLE, 12'hFFF, 0);
		send_event(OP_X_SAMPLE, 12'd1, 10);
		send_event(OP_Y_SAMPLE, 12'd1, 0);
		send_event(OP_RELEASE, 12'd0, 300);
		// long press one past the limit
		send_event(OP_X_SAMPLE, 12'd2048, 7);
		send_event(OP_Y_SAMPLE, 12'd2048, 0);
		send_event(OP_RELEASE, 12'd0, 501);
		// tap held exactly at the limit, ticks just inside and at the window
		send_event(OP_X_SAMPLE, 12'd512, 9);
		send_event(OP_Y_SAMPLE, 12'd300, 0);
		send_event(OP_RELEASE, 12'd0, 500);
		send_event(OP_X_SAMPLE, 12'd0, 1);
		send_event(OP_TICK, 12'd0, 798);
		send_event(OP_TICK, 12'd0, 1);
		// double click with the second touch one short of the window
		send_event(OP_X_SAMPLE, 12'd700, 4);
		send_event(OP_Y_SAMPLE, 12'd200, 0);
		send_event(OP_RELEASE, 12'd0, 10);
		send_event(OP_X_SAMPLE, 12'd900, 799);
		send_event(OP_Y_SAMPLE, 12'd100, 0);
		send_event(OP_RELEASE, 12'd0, 20);
		// y-only contact dropped while pending, then a touch after the window
		send_event(OP_X_SAMPLE, 12'd300, 6);
		send_event(OP_Y_SAMPLE, 12'd300, 0);
		send_event(OP_RELEASE, 12'd0, 50);
		send_event(OP_Y_SAMPLE, 12'd50, 5);
		send_event(OP_RELEASE, 12'd0, 5);
		send_event(OP_X_SAMPLE, 12'd4000, 790);
		send_event(OP_Y_SAMPLE, 12'd4000, 0);
		send_event(OP_RELEASE, 12'd0, 100);
	endtask

	task automatic random_sequence();
		int unsigned n;
		int unsigned press;
		int unsigned window;
		opcode_t     axis;
		press   = tracker.press_limit;
		window  = tracker.window_ms;
		idle_on = ($urandom_range(0, 4) != 0);
		case ($urandom_range(0, 9))
		0, 1, 2: begin
			// swipe: several points, then release
			send_point($urandom_range(0, 40));
			n = $urandom_range(1, 3);
			repeat (n) send_point($urandom_range(0, 30));
			send_event(OP_RELEASE, 12'd0, pick_span(press));
		end
		3, 4: begin
			// single point: tap or long press around the limit
			send_point($urandom_range(0, 40));
			send_event(OP_RELEASE, 12'd0, pick_span(press));
		end
		5: begin
			// tap, then a tick or a second touch around the window
			send_point($urandom_range(0, 40));
			send_event(OP_RELEASE, 12'd0, $urandom_range(0, press));
			if ($urandom_range(0, 1)) begin
				send_event(OP_TICK, 12'd0, pick_span(window));
			end else begin
				send_point(pick_span(window));
				send_event(OP_RELEASE, 12'd0, $urandom_range(0, 40));
			end
		end
		6: begin
			// contact on one axis only
			axis = $urandom_range(0, 1) ? OP_Y_SAMPLE : OP_X_SAMPLE;
			n = $urandom_range(1, 2);
			repeat (n) send_event(axis, pick_coord(), $urandom_range(0, 20));
			send_event(OP_RELEASE, 12'd0, pick_span(press));
		end
		default: begin
			// noise: any opcode, zeros allowed
			n = $urandom_range(1, 4);
			repeat (n)
				send_event(opcode_t'($urandom_range(0, 3)), noise_coord(),
					$urandom_range(0, 1) ? pick_span(window) : pick_span(press));
		end
		endcase
	endtask

	initial begin : stimulus
		logic [15:0] press_set[5];
		logic [15:0] window_set[5];
		int unsigned target;
		press_set  = '{16'd0, 16'hFFFF, 16'($urandom_range(1, 1500)), 16'd0, 16'd500};
		window_set = '{16'd0, 16'hFFFF, 16'($urandom_range(1, 1500)), 16'hFFFF, 16'd800};
		stamp_ms   = 32'hFFFF_FF00;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		directed_events();
		for (int p = 0; p < 5; p++) begin
			settle();
			program_regs(press_set[p], window_set[p]);
			// start the third phase with a fresh random time base
			if (p == 2)
				stamp_ms = $urandom();
			if (p == 1 || p == 3)
				chokes_asked++;
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) random_sequence();
		end
		settle();
		repeat (4) @(negedge clk);
		if (tracker.failures == 0 && tracker.outstanding() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/tgc_pkg.sv
rtl/tgc_scale.sv
rtl/tgc_swipe.sv
rtl/touch_gesture_classifier.sv
tb/touch_gesture_classifier_test.sv
